@@ hdl/hsgim_pkg.sv @@
// ----------------------------------------------------------------------------
// Hex to square grid index map: shared types and constants
// Field widths, internal arithmetic widths and configuration register indexes.
// ----------------------------------------------------------------------------
package hsgim_pkg;

  localparam int unsigned CW   = 12;  // square cell column and row
  localparam int unsigned SW   = 32;  // grid steps, Q16.16
  localparam int unsigned NW   = 13;  // hex column and row counts
  localparam int unsigned XW   = 44;  // cell position and quotients
  localparam int unsigned RW   = XW - 1;
  localparam int unsigned DXW  = 34;  // distances in units of 2^-17
  localparam int unsigned SQW  = 2 * DXW;
  localparam int unsigned DSW  = SQW + 1;
  localparam int unsigned OFW  = NW + 1;
  localparam int unsigned AW   = XW + 1;
  localparam int unsigned BW   = RW + OFW;
  localparam int unsigned PW   = BW + 1;
  localparam int unsigned TW   = 2 * NW + 1;
  localparam int unsigned IW   = 24;
  localparam int unsigned OW   = 48;
  localparam int unsigned CIW  = 3;

  localparam logic [CIW-1:0] CFG_SQ_X_STEP  = 3'd0;
  localparam logic [CIW-1:0] CFG_SQ_Y_STEP  = 3'd1;
  localparam logic [CIW-1:0] CFG_HEX_X_STEP = 3'd2;
  localparam logic [CIW-1:0] CFG_HEX_Y_STEP = 3'd3;
  localparam logic [CIW-1:0] CFG_ODD_COLS   = 3'd4;
  localparam logic [CIW-1:0] CFG_EVEN_COLS  = 3'd5;
  localparam logic [CIW-1:0] CFG_ROW_COUNT  = 3'd6;

  typedef struct packed {
    logic [XW-1:0] nqx;
    logic [SW-1:0] rmx;
    logic [XW-1:0] nqy;
    logic [SW-1:0] rmy;
    logic [XW-1:0] xs;
    logic [XW-1:0] ys;
  } div_t;

endpackage

@@ hdl/hex_to_square_grid_index_map_core.sv @@
// ----------------------------------------------------------------------------
// Hex to square grid index map core
// Maps each square grid cell to the nearest point of a hexagonal scan.
// ----------------------------------------------------------------------------
// The block takes one cell beat per cycle while the output is not stalled and
// returns one result beat per cell, in order. The two restoring dividers for
// the hex row and column form most of the pipeline; they resolve one quotient
// bit per pipeline stage over 44 stages. A stall on the output holds the whole
// pipeline. Configuration must only be written while no beat is in flight.
module hex_to_square_grid_index_map_core
  import hsgim_pkg::*;
#(
  parameter int unsigned MAX_COLS = 4096,
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIW-1:0]    cfg_idx_i,
  input  logic [SW-1:0]     cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CW-1:0]     square_col_i,
  input  logic [CW-1:0]     square_row_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IW-1:0]     source_index_o,
  output logic [OW-1:0]     square_x_o,
  output logic [OW-1:0]     square_y_o,
  output logic              took_upper_row_o,
  output logic              index_out_of_scan_o
);

  logic [SW-1:0] sq_x_step_q, sq_y_step_q, hex_x_step_q, hex_y_step_q;
  logic [NW-1:0] odd_cols_q, even_cols_q, row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_x_step_q  <= SW'(65536);
      sq_y_step_q  <= SW'(65536);
      hex_x_step_q <= SW'(65536);
      hex_y_step_q <= SW'(65536);
      odd_cols_q   <= '0;
      even_cols_q  <= '0;
      row_count_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SQ_X_STEP:  sq_x_step_q  <= cfg_data_i;
        CFG_SQ_Y_STEP:  sq_y_step_q  <= cfg_data_i;
        CFG_HEX_X_STEP: hex_x_step_q <= cfg_data_i;
        CFG_HEX_Y_STEP: hex_y_step_q <= cfg_data_i;
        CFG_ODD_COLS:   odd_cols_q   <= cfg_data_i[NW-1:0];
        CFG_EVEN_COLS:  even_cols_q  <= cfg_data_i[NW-1:0];
        CFG_ROW_COUNT:  row_count_q  <= cfg_data_i[NW-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] hx, hy;
  assign hx = (hex_x_step_q == '0) ? SW'(1) : hex_x_step_q;
  assign hy = (hex_y_step_q == '0) ? SW'(1) : hex_y_step_q;

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Input stage with limit clamping.
  logic          s0_v_q;
  logic [CW-1:0] s0_col_q, s0_row_q;
  logic [CW-1:0] col_c, row_c;
  assign col_c = (32'(square_col_i) > 32'(MAX_COLS - 1)) ? CW'(MAX_COLS - 1) : square_col_i;
  assign row_c = (32'(square_row_i) > 32'(MAX_ROWS - 1)) ? CW'(MAX_ROWS - 1) : square_row_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_col_q <= col_c;
      s0_row_q <= row_c;
    end
  end

  // Position multiply, feeding the divider pipeline.
  logic dv_v_q [0:XW];
  div_t dv_q   [0:XW];
  logic [XW-1:0] xs_d, ys_d;
  assign xs_d = XW'(s0_col_q) * XW'(sq_x_step_q);
  assign ys_d = XW'(s0_row_q) * XW'(sq_y_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].nqx <= xs_d;
      dv_q[0].rmx <= '0;
      dv_q[0].nqy <= ys_d;
      dv_q[0].rmy <= '0;
      dv_q[0].xs  <= xs_d;
      dv_q[0].ys  <= ys_d;
    end
  end

  for (genvar k = 0; k < XW; k++) begin : g_div
    logic [SW:0] tx, ty;
    logic        qx, qy;
    assign tx = {dv_q[k].rmx, dv_q[k].nqx[XW-1]};
    assign ty = {dv_q[k].rmy, dv_q[k].nqy[XW-1]};
    assign qx = tx >= {1'b0, hx};
    assign qy = ty >= {1'b0, hy};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1].nqx <= {dv_q[k].nqx[XW-2:0], qx};
        dv_q[k+1].rmx <= qx ? SW'(tx - {1'b0, hx}) : tx[SW-1:0];
        dv_q[k+1].nqy <= {dv_q[k].nqy[XW-2:0], qy};
        dv_q[k+1].rmy <= qy ? SW'(ty - {1'b0, hy}) : ty[SW-1:0];
        dv_q[k+1].xs  <= dv_q[k].xs;
        dv_q[k+1].ys  <= dv_q[k].ys;
      end
    end
  end

  // Stage A: candidates and distance components.
  div_t           dq;
  logic [XW:0]    x2;
  logic [DXW-1:0] dxa, dxs, dy1, dy2, dx1, dx2;
  logic [XW-1:0]  cs, c1, c2;
  logic           odd_row, last_row;
  logic [OFW-1:0] off1, off2;

  assign dq       = dv_q[XW];
  assign x2       = {dq.xs, 1'b0};
  assign dxa      = {1'b0, dq.rmx, 1'b0};
  assign dy1      = {1'b0, dq.rmy, 1'b0};
  assign dy2      = {1'b0, hy, 1'b0} - dy1;
  assign odd_row  = dq.nqy[0];
  assign last_row = (row_count_q != '0) && (dq.nqy == XW'(row_count_q - NW'(1)));

  always_comb begin
    if (x2 < AW'(hx)) begin
      cs  = '0;
      dxs = DXW'(hx) - DXW'(x2);
    end else if ({1'b0, dq.rmx, 1'b0} >= DXW'(hx)) begin
      cs  = dq.nqx;
      dxs = {1'b0, dq.rmx, 1'b0} - DXW'(hx);
    end else begin
      cs  = dq.nqx - XW'(1);
      dxs = {1'b0, dq.rmx, 1'b0} + DXW'(hx);
    end
    if (odd_row) begin
      c1   = cs;
      dx1  = dxs;
      c2   = dq.nqx;
      dx2  = dxa;
      off1 = OFW'(odd_cols_q);
      off2 = OFW'(odd_cols_q) + OFW'(even_cols_q);
    end else begin
      c1   = dq.nqx;
      dx1  = dxa;
      c2   = cs;
      dx2  = dxs;
      off1 = '0;
      off2 = OFW'(odd_cols_q);
    end
  end

  logic           sa_v_q, sa_last_q;
  logic [DXW-1:0] sa_dx1_q, sa_dx2_q, sa_dy1_q, sa_dy2_q;
  logic [AW-1:0]  sa_a1_q, sa_a2_q;
  logic [RW-1:0]  sa_r_q;
  logic [XW-1:0]  sa_xs_q, sa_ys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_v_q <= 1'b0;
    end else if (adv) begin
      sa_v_q <= dv_v_q[XW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_last_q <= last_row;
      sa_dx1_q  <= dx1;
      sa_dx2_q  <= dx2;
      sa_dy1_q  <= dy1;
      sa_dy2_q  <= dy2;
      sa_a1_q   <= AW'(c1) + AW'(off1);
      sa_a2_q   <= AW'(c2) + AW'(off2);
      sa_r_q    <= dq.nqy[XW-1:1];
      sa_xs_q   <= dq.xs;
      sa_ys_q   <= dq.ys;
    end
  end

  // Stage B: squares, row base and scan total.
  logic           sb_v_q, sb_last_q;
  logic [SQW-1:0] sb_x1_q, sb_x2_q, sb_y1_q, sb_y2_q;
  logic [BW-1:0]  sb_base_q;
  logic [AW-1:0]  sb_a1_q, sb_a2_q;
  logic [TW-1:0]  sb_tot_q;
  logic [XW-1:0]  sb_xs_q, sb_ys_q;
  logic [NW-1:0]  rows_hi, rows_lo;

  assign rows_hi = NW'((OFW'(row_count_q) + OFW'(1)) >> 1);
  assign rows_lo = row_count_q >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_v_q <= 1'b0;
    end else if (adv) begin
      sb_v_q <= sa_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_last_q <= sa_last_q;
      sb_x1_q   <= SQW'(sa_dx1_q) * SQW'(sa_dx1_q);
      sb_x2_q   <= SQW'(sa_dx2_q) * SQW'(sa_dx2_q);
      sb_y1_q   <= SQW'(sa_dy1_q) * SQW'(sa_dy1_q);
      sb_y2_q   <= SQW'(sa_dy2_q) * SQW'(sa_dy2_q);
      sb_base_q <= BW'(sa_r_q) * BW'(OFW'(odd_cols_q) + OFW'(even_cols_q));
      sb_a1_q   <= sa_a1_q;
      sb_a2_q   <= sa_a2_q;
      sb_tot_q  <= TW'(rows_hi) * TW'(odd_cols_q) + TW'(rows_lo) * TW'(even_cols_q);
      sb_xs_q   <= sa_xs_q;
      sb_ys_q   <= sa_ys_q;
    end
  end

  // Stage C: distance sums and candidate indexes.
  logic           sc_v_q, sc_last_q;
  logic [DSW-1:0] sc_d1_q, sc_d2_q;
  logic [PW-1:0]  sc_p1_q, sc_p2_q;
  logic [TW-1:0]  sc_tot_q;
  logic [XW-1:0]  sc_xs_q, sc_ys_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (adv) begin
      sc_v_q <= sb_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_last_q <= sb_last_q;
      sc_d1_q   <= DSW'(sb_x1_q) + DSW'(sb_y1_q);
      sc_d2_q   <= DSW'(sb_x2_q) + DSW'(sb_y2_q);
      sc_p1_q   <= PW'(sb_base_q) + PW'(sb_a1_q);
      sc_p2_q   <= PW'(sb_base_q) + PW'(sb_a2_q);
      sc_tot_q  <= sb_tot_q;
      sc_xs_q   <= sb_xs_q;
      sc_ys_q   <= sb_ys_q;
    end
  end

  // Stage D: choice and output register.
  logic          upper;
  logic [PW-1:0] point;
  assign upper = !((sc_d1_q <= sc_d2_q) || sc_last_q);
  assign point = upper ? sc_p2_q : sc_p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= sc_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      source_index_o      <= (point > PW'({IW{1'b1}})) ? {IW{1'b1}} : point[IW-1:0];
      square_x_o          <= OW'(sc_xs_q);
      square_y_o          <= OW'(sc_ys_q);
      took_upper_row_o    <= upper;
      index_out_of_scan_o <= point >= PW'(sc_tot_q);
    end
  end

endmodule

@@ test/tb_hex_to_square_grid_index_map_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the hex to square grid index map core
// Drives square grid cells through a bursty sender against a receiver that
// stalls on its own pattern. Every result beat is checked field by field against
// fixed values or a predictor of the nearest hex point, over several grid settings.
// ----------------------------------------------------------------------------
module tb_hex_to_square_grid_index_map_core;
  import hsgim_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct {
    longint unsigned sx, sy, hx, hy, odd_cols, even_cols, rows;
  } grid_cfg_t;

  typedef struct {
    logic [IW-1:0] source_index;
    logic [OW-1:0] square_x;
    logic [OW-1:0] square_y;
    logic          took_upper_row;
    logic          index_out_of_scan;
  } cell_map_t;

  typedef struct {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    bit            typed;
    cell_map_t     want;
  } cell_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIW-1:0] cfg_idx = CFG_SQ_X_STEP;
  logic [SW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [CW-1:0] square_col = '0;
  logic [CW-1:0] square_row = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [IW-1:0] source_index;
  logic [OW-1:0] square_x, square_y;
  logic took_upper_row, index_out_of_scan;

  grid_cfg_t grid;
  cell_map_t expected_maps[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned stall_cyc = 0;

  hex_to_square_grid_index_map_core uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .square_col_i       (square_col),
    .square_row_i       (square_row),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .source_index_o     (source_index),
    .square_x_o         (square_x),
    .square_y_o         (square_y),
    .took_upper_row_o   (took_upper_row),
    .index_out_of_scan_o(index_out_of_scan)
  );

  always #5 clk = ~clk;

  function automatic cell_map_t map_cell(logic [CW-1:0] c, logic [CW-1:0] r);
    longint unsigned hx, hy, xs, ys, x2, row1, dy1, dy2, ca, dxa, cs, dxs;
    longint unsigned dx1, dx2, p1, p2, pt, tot, half;
    logic [127:0] d1, d2;
    bit last_row, upper;
    cell_map_t m;
    hx = (grid.hx == 0) ? 1 : grid.hx;
    hy = (grid.hy == 0) ? 1 : grid.hy;
    xs = 64'(c) * grid.sx;
    ys = 64'(r) * grid.sy;
    x2 = xs << 1;
    row1 = ys / hy;
    dy1 = 2 * (ys - row1 * hy);
    dy2 = 2 * hy - dy1;
    ca = xs / hx;
    dxa = 2 * (xs - ca * hx);
    if (x2 < hx) begin
      cs = 0;
      dxs = hx - x2;
    end else begin
      cs = (x2 - hx) / (2 * hx);
      dxs = (x2 - hx) % (2 * hx);
    end
    half = row1 >> 1;
    if (row1[0] == 1'b0) begin
      dx1 = dxa;
      dx2 = dxs;
      p1 = half * grid.even_cols + half * grid.odd_cols + ca;
      p2 = half * grid.even_cols + (half + 1) * grid.odd_cols + cs;
    end else begin
      dx1 = dxs;
      dx2 = dxa;
      p1 = half * grid.even_cols + (half + 1) * grid.odd_cols + cs;
      p2 = (half + 1) * grid.even_cols + (half + 1) * grid.odd_cols + ca;
    end
    d1 = 128'(dx1) * 128'(dx1) + 128'(dy1) * 128'(dy1);
    d2 = 128'(dx2) * 128'(dx2) + 128'(dy2) * 128'(dy2);
    last_row = (grid.rows != 0) && (row1 == grid.rows - 1);
    upper = !((d1 <= d2) || last_row);
    pt = upper ? p2 : p1;
    tot = ((grid.rows + 1) >> 1) * grid.odd_cols + (grid.rows >> 1) * grid.even_cols;
    m.source_index = (pt > 64'hFFFFFF) ? 24'hFFFFFF : pt[IW-1:0];
    m.square_x = xs[OW-1:0];
    m.square_y = ys[OW-1:0];
    m.took_upper_row = upper;
    m.index_out_of_scan = (pt >= tot);
    return m;
  endfunction

  task automatic write_reg(logic [CIW-1:0] idx, logic [SW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  task automatic load_grid(grid_cfg_t g);
    write_reg(CFG_SQ_X_STEP, g.sx[SW-1:0]);
    write_reg(CFG_SQ_Y_STEP, g.sy[SW-1:0]);
    write_reg(CFG_HEX_X_STEP, g.hx[SW-1:0]);
    write_reg(CFG_HEX_Y_STEP, g.hy[SW-1:0]);
    write_reg(CFG_ODD_COLS, SW'(g.odd_cols));
    write_reg(CFG_EVEN_COLS, SW'(g.even_cols));
    write_reg(CFG_ROW_COUNT, SW'(g.rows));
    cfg_we <= 1'b0;
    grid = g;
    grid.odd_cols = g.odd_cols & 64'h1FFF;
    grid.even_cols = g.even_cols & 64'h1FFF;
    grid.rows = g.rows & 64'h1FFF;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cell(logic [CW-1:0] c, logic [CW-1:0] r, bit typed,
                           cell_map_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    square_col <= c;
    square_row <= r;
    do @(posedge clk); while (in_stall);
    expected_maps.insert(expected_maps.size(), typed ? want : map_cell(c, r));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
  endtask

  function automatic longint unsigned pick_step();
    case ($urandom_range(0, 5))
      0: return 64'($urandom());
      1: return 64'($urandom_range(1, 255));
      default: return 64'($urandom_range(16384, 262144));
    endcase
  endfunction

  always @(negedge clk) begin
    logic stall_next;
    stall_cyc++;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      stall_next = 1'b1;
    end else begin
      case ((stall_cyc / 256) % 4)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 3) == 0);
        2: stall_next = ($urandom_range(0, 3) != 0);
        default: stall_next = ((stall_cyc % 5) < 2);
      endcase
    end
    out_stall <= stall_next;
  end

  always @(posedge clk) begin
    cell_map_t want;
    if (out_valid && !out_stall) begin
      if (expected_maps.size() == 0) begin
        $error("result beat with no expectation waiting");
        failures++;
      end else begin
        want = expected_maps.pop_front();
        if (source_index !== want.source_index) begin
          $error("source_index: expected %0d, got %0d", want.source_index, source_index);
          failures++;
        end
        if (square_x !== want.square_x) begin
          $error("square_x: expected %0h, got %0h", want.square_x, square_x);
          failures++;
        end
        if (square_y !== want.square_y) begin
          $error("square_y: expected %0h, got %0h", want.square_y, square_y);
          failures++;
        end
        if (took_upper_row !== want.took_upper_row) begin
          $error("took_upper_row: expected %0b, got %0b", want.took_upper_row,
                 took_upper_row);
          failures++;
        end
        if (index_out_of_scan !== want.index_out_of_scan) begin
          $error("index_out_of_scan: expected %0b, got %0b", want.index_out_of_scan,
                 index_out_of_scan);
          failures++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** hex_to_square_grid_index_map_core: FAILED **");
      $finish;
    end
  end

  initial begin
    cell_row_t cells[$];
    grid_cfg_t g;
    cell_map_t none;
    logic [CW-1:0] c, r;
    none = '{default: '0};
    grid = '{sx: 65536, sy: 65536, hx: 65536, hy: 65536,
             odd_cols: 0, even_cols: 0, rows: 0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Steps stay at their reset value of one; three hex rows of 5, 4 and 5.
    load_grid('{sx: 65536, sy: 65536, hx: 65536, hy: 65536,
                odd_cols: 5, even_cols: 4, rows: 3});
    cells.insert(cells.size(), '{12'd0, 12'd0, 1'b1, '{24'd0, 48'd0, 48'd0, 1'b0, 1'b0}});
    cells.insert(cells.size(), '{12'd4095, 12'd0, 1'b1,
                                 '{24'd4095, 48'h0FFF0000, 48'd0, 1'b0, 1'b1}});
    cells.insert(cells.size(), '{12'd0, 12'd4095, 1'b0, none});
    cells.insert(cells.size(), '{12'd4095, 12'd4095, 1'b0, none});
    cells.insert(cells.size(), '{12'd0, 12'd1, 1'b0, none});
    cells.insert(cells.size(), '{12'd1, 12'd1, 1'b0, none});
    cells.insert(cells.size(), '{12'd2, 12'd2, 1'b0, none});
    cells.insert(cells.size(), '{12'd4, 12'd2, 1'b0, none});
    cells.insert(cells.size(), '{12'd3, 12'd1, 1'b0, none});
    cells.insert(cells.size(), '{12'd2048, 12'd2048, 1'b0, none});
    cells.insert(cells.size(), '{12'hAAA, 12'h555, 1'b0, none});
    cells.insert(cells.size(), '{12'h555, 12'hAAA, 1'b0, none});
    foreach (cells[i]) send_cell(cells[i].col, cells[i].row, cells[i].typed, cells[i].want);
    drain();

    // Fractional positions, so that both candidates and both rows come into play.
    load_grid('{sx: 40000, sy: 30000, hx: 65536, hy: 56756,
                odd_cols: 7, even_cols: 6, rows: 9});
    for (int i = 0; i < 12; i++) begin
      send_cell(CW'($urandom_range(0, 12)), CW'($urandom_range(0, 20)), 1'b0, none);
    end
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: g = '{64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF, 4096, 4096, 4096};
        1: g = '{0, 0, 0, 0, 0, 0, 0};
        2: g = '{1, 1, 1, 1, 4096, 0, 1};
        3: g = '{65536, 65536, 98304, 56756, 100, 99, 200};
        4: g = '{64'hFFFFFFFF, 1, 1, 64'hFFFFFFFF, 8191, 8191, 8191};
        default: g = '{pick_step(), pick_step(), pick_step(), pick_step(),
                       64'($urandom_range(0, 4096)), 64'($urandom_range(0, 4096)),
                       64'($urandom_range(0, 4096))};
      endcase
      load_grid(g);
      if (ph == 3) hold_req = 1'b1;
      for (int i = 0; i < 185; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            c = CW'($urandom());
            r = CW'($urandom());
          end
          1: begin
            c = CW'($urandom_range(0, 31));
            r = CW'($urandom_range(0, 31));
          end
          2: begin
            c = CW'($urandom());
            r = (grid.rows != 0 && grid.rows <= 4096) ? CW'(grid.rows - 1) : CW'($urandom());
          end
          default: begin
            c = $urandom_range(0, 2) == 0 ? 12'd0 : 12'd4095;
            r = CW'($urandom());
          end
        endcase
        send_cell(c, r, 1'b0, none);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0 && expected_maps.size() == 0) begin
      $display("** hex_to_square_grid_index_map_core: PASSED **");
    end else begin
      $display("** hex_to_square_grid_index_map_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/hsgim_pkg.sv
hdl/hex_to_square_grid_index_map_core.sv
test/tb_hex_to_square_grid_index_map_core.sv
